[sv/scsd_pkg.sv]
// shared types, constants and parse microcode for the serial command seven-segment driver
package scsd_pkg;

   localparam int LINE_CHARS  = 9;
   localparam int DIGIT_COUNT = 4;
   localparam int LEN_W       = $clog2(LINE_CHARS + 1);
   localparam int IDX_W       = $clog2(LINE_CHARS);
   localparam int POS_W       = $clog2(DIGIT_COUNT);
   localparam int MAG_W       = 14;
   localparam int DATA_IN_W   = 8;
   localparam int DATA_OUT_W  = 16;

   localparam logic [MAG_W-1:0] SCORE_MAX = 14'd9999;

   // characters with a meaning of their own
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_X     = 8'h58;

   // led codes
   localparam logic [2:0] LED_GREEN  = 3'd1;
   localparam logic [2:0] LED_SECOND = 3'd2;
   localparam logic [2:0] LED_RED    = 3'd4;
   localparam logic [2:0] LED_OFF    = 3'd0;

   localparam logic [6:0] SEG_BLANK = 7'h7F;

   // transfer kind on the request side
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef logic [7:0] char_type;
   typedef char_type line_array_type [LINE_CHARS];
   typedef logic [3:0] bcd_type;
   typedef bcd_type digit_array_type [DIGIT_COUNT];

   // parse program steps
   typedef logic [3:0] step_type;
   localparam step_type ST_CHECK = 4'd0;
   localparam step_type ST_SKIP  = 4'd1;
   localparam step_type ST_SIGN  = 4'd2;
   localparam step_type ST_DIGIT = 4'd3;
   localparam step_type ST_LOAD  = 4'd4;
   localparam step_type ST_D1000 = 4'd5;
   localparam step_type ST_D100  = 4'd6;
   localparam step_type ST_D10   = 4'd7;
   localparam step_type ST_ONES  = 4'd8;
   localparam step_type ST_DONE  = 4'd9;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_HEADER,
      C_SPACE,
      C_SIGN,
      C_DIGIT,
      C_GE1000,
      C_GE100,
      C_GE10
   } cond_type;

   typedef enum logic [3:0] {
      A_INIT,
      A_NEXT,
      A_SIGN,
      A_ACCUM,
      A_LOAD,
      A_SUB1000,
      A_SUB100,
      A_SUB10,
      A_ONES,
      A_END
   } act_type;

   // the action runs only when the condition holds
   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } uword_type;

   typedef struct packed {
      logic busy;
      logic digit_load;
      logic line_done;
   } seq_status_type;

   function automatic uword_type ucode(step_type step);
      uword_type w;
      unique case (step)
         ST_CHECK: w = '{A_INIT,    C_HEADER, ST_SKIP,  ST_DONE};
         ST_SKIP:  w = '{A_NEXT,    C_SPACE,  ST_SKIP,  ST_SIGN};
         ST_SIGN:  w = '{A_SIGN,    C_SIGN,   ST_DIGIT, ST_DIGIT};
         ST_DIGIT: w = '{A_ACCUM,   C_DIGIT,  ST_DIGIT, ST_LOAD};
         ST_LOAD:  w = '{A_LOAD,    C_ALWAYS, ST_D1000, ST_D1000};
         ST_D1000: w = '{A_SUB1000, C_GE1000, ST_D1000, ST_D100};
         ST_D100:  w = '{A_SUB100,  C_GE100,  ST_D100,  ST_D10};
         ST_D10:   w = '{A_SUB10,   C_GE10,   ST_D10,   ST_ONES};
         ST_ONES:  w = '{A_ONES,    C_ALWAYS, ST_DONE,  ST_DONE};
         default:  w = '{A_END,     C_ALWAYS, ST_DONE,  ST_DONE};
      endcase
      return w;
   endfunction

   // active-low patterns, segment a in bit 0
   function automatic logic [6:0] seg_pattern(bcd_type d);
      logic [7:0] p;
      unique case (d)
         4'd0:    p = 8'hC0;
         4'd1:    p = 8'hF9;
         4'd2:    p = 8'hA4;
         4'd3:    p = 8'hB0;
         4'd4:    p = 8'h99;
         4'd5:    p = 8'h92;
         4'd6:    p = 8'h82;
         4'd7:    p = 8'hF8;
         4'd8:    p = 8'h80;
         4'd9:    p = 8'h90;
         default: p = 8'hC0;
      endcase
      return p[6:0];
   endfunction

endpackage

[sv/scsd_seq.sv]
// microcoded line parser: header check, atoi scan, clamp and decimal split
module scsd_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [scsd_pkg::LEN_W-1:0]    line_len,
   input  scsd_pkg::line_array_type      line,
   output scsd_pkg::digit_array_type     digits,
   output scsd_pkg::seq_status_type      status
);
   import scsd_pkg::*;

   step_type         step_ff, step_in;
   logic             run_ff, run_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic [MAG_W-1:0] rem_ff, rem_in;
   bcd_type          cnt_ff [3];
   bcd_type          cnt_in [3];

   uword_type        uw;
   logic             hit;
   char_type         ch;
   logic             in_range;
   logic             header_ok;
   logic [16:0]      prod;

   assign uw       = ucode(step_ff);
   assign in_range = idx_ff < line_len;
   assign ch       = line[idx_ff[IDX_W-1:0]];
   assign header_ok = (line_len >= LEN_W'(4)) && line[0] == CH_S && line[1] == CH_C
                      && line[2] == CH_R && line[3] == CH_COLON;
   assign prod     = 17'(mag_ff) * 17'd10 + 17'(ch[3:0]);

   always_comb begin
      unique case (uw.cond)
         C_ALWAYS: hit = 1'b1;
         C_HEADER: hit = header_ok;
         C_SPACE:  hit = in_range && (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR));
         C_SIGN:   hit = in_range && (ch == CH_PLUS || ch == CH_MINUS);
         C_DIGIT:  hit = in_range && ch >= CH_ZERO && ch <= CH_NINE;
         C_GE1000: hit = rem_ff >= MAG_W'(1000);
         C_GE100:  hit = rem_ff >= MAG_W'(100);
         C_GE10:   hit = rem_ff >= MAG_W'(10);
      endcase
   end

   always_comb begin
      step_in = step_ff;
      run_in  = run_ff;
      idx_in  = idx_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      status  = '0;
      status.busy = run_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = ST_CHECK;
      end else if (run_ff) begin
         step_in = hit ? uw.on_true : uw.on_false;
         if (hit) begin
            unique case (uw.act)
               A_INIT: begin
                  idx_in = LEN_W'(4);
                  mag_in = '0;
                  neg_in = 1'b0;
               end
               A_NEXT: idx_in = idx_ff + 1'b1;
               A_SIGN: begin
                  neg_in = (ch == CH_MINUS);
                  idx_in = idx_ff + 1'b1;
               end
               A_ACCUM: begin
                  // saturate just above the display range
                  mag_in = (prod > 17'(SCORE_MAX)) ? SCORE_MAX + 1'b1 : prod[MAG_W-1:0];
                  idx_in = idx_ff + 1'b1;
               end
               A_LOAD: begin
                  if (neg_ff) rem_in = '0;
                  else rem_in = (mag_ff > SCORE_MAX) ? SCORE_MAX : mag_ff;
                  cnt_in = '{default: '0};
               end
               A_SUB1000: begin
                  rem_in    = rem_ff - MAG_W'(1000);
                  cnt_in[0] = cnt_ff[0] + 1'b1;
               end
               A_SUB100: begin
                  rem_in    = rem_ff - MAG_W'(100);
                  cnt_in[1] = cnt_ff[1] + 1'b1;
               end
               A_SUB10: begin
                  rem_in    = rem_ff - MAG_W'(10);
                  cnt_in[2] = cnt_ff[2] + 1'b1;
               end
               A_ONES: status.digit_load = 1'b1;
               A_END: begin
                  status.line_done = 1'b1;
                  run_in = 1'b0;
               end
               default: run_in = 1'b0;
            endcase
         end
      end
   end

   assign digits[0] = cnt_ff[0];
   assign digits[1] = cnt_ff[1];
   assign digits[2] = cnt_ff[2];
   assign digits[3] = rem_ff[3:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= ST_DONE;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
      idx_ff <= idx_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

endmodule

[sv/serial_command_seven_segment_driver_top.sv]
// top level of the serial command seven-segment driver
// Each request transfer is one event: a received serial byte (tuser 0) or a display scan
// tick (tuser 1), and each gives exactly one response transfer carrying the segment
// drive, the digit enable and the led state, built in the state registers and then moved
// into the output register. The next request is taken as soon as the previous
// response has moved into the output register, even while that response still waits.
// A CR or LF ends the line and starts the parse program of the line store; while it
// runs, tready stays low. A line not starting SCR: goes straight to the end of the
// program; a score line runs the scan, the clamp and the decimal split, which removes
// one thousand, hundred or ten per step of the sequencer.
module serial_command_seven_segment_driver_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [scsd_pkg::DATA_IN_W-1:0]    req_tdata,   // rx_byte
   input  logic                              req_tuser,   // mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [scsd_pkg::DATA_OUT_W-1:0]   rsp_tdata    // segments, digit_enable, led_state
);
   import scsd_pkg::*;

   // line store, no reset: only entries below the length are ever read
   line_array_type   line_ff;
   logic [LEN_W-1:0] len_ff, len_in;
   digit_array_type  digit_ff;
   logic [POS_W-1:0] scan_ff, scan_in;
   logic [2:0]       led_ff, led_in;
   logic [6:0]       seg_ff, seg_in;
   logic [3:0]       drv_ff, drv_in;
   logic             pend_ff, pend_in;     // a response is ready in the state registers
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DATA_OUT_W-1:0] rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             is_byte;
   logic             line_end;
   logic             line_we;
   logic             out_load;
   bcd_type          scan_digit;

   digit_array_type  seq_digits;
   seq_status_type   seq_status;

   // take a request only with the sequencer idle and no response queued behind the output
   assign req_tready = !seq_status.busy && !pend_ff;
   assign accept     = req_tvalid && req_tready;
   assign is_byte    = (req_tuser == MODE_BYTE);
   assign line_end   = is_byte && (req_tdata == CH_LF || req_tdata == CH_CR);
   assign line_we    = accept && is_byte && !line_end && (len_ff < LEN_W'(LINE_CHARS));
   assign out_load   = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign scan_digit = digit_ff[scan_ff];

   scsd_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && line_end),
      .line_len (len_ff),
      .line     (line_ff),
      .digits   (seq_digits),
      .status   (seq_status)
   );

   always_comb begin
      len_in  = len_ff;
      scan_in = scan_ff;
      led_in  = led_ff;
      seg_in  = seg_ff;
      drv_in  = drv_ff;
      pend_in = pend_ff;
      if (out_load) pend_in = 1'b0;
      if (accept) begin
         pend_in = 1'b1;
         if (is_byte) begin
            // led commands act whether or not the byte fits the line
            priority if (req_tdata == CH_G) led_in = LED_GREEN;
            else if (req_tdata == CH_P) led_in = LED_SECOND;
            else if (req_tdata == CH_E) led_in = LED_RED;
            else if (req_tdata == CH_X) led_in = LED_OFF;
            else led_in = led_ff;
            if (line_we) len_in = len_ff + 1'b1;
         end else begin
            // scan tick: drive the current digit, then rotate
            seg_in  = seg_pattern((scan_digit > 4'd9) ? 4'd0 : scan_digit);
            drv_in  = 4'(1) << scan_ff;
            scan_in = scan_ff + 1'b1;
         end
      end
      if (seq_status.line_done) len_in = '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, led_ff, drv_ff, seg_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         digit_ff     <= '{default: '0};
         scan_ff      <= '0;
         led_ff       <= LED_RED;
         seg_ff       <= SEG_BLANK;
         drv_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         scan_ff      <= scan_in;
         led_ff       <= led_in;
         seg_ff       <= seg_in;
         drv_ff       <= drv_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (seq_status.digit_load) digit_ff <= seq_digits;
      end
      rsp_data_ff <= rsp_data_in;
      if (line_we) line_ff[len_ff[IDX_W-1:0]] <= req_tdata;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[sv/scsd_check.sv]
// port-level checks for the serial command seven-segment driver, bound to the top level
module scsd_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [scsd_pkg::DATA_OUT_W-1:0]   rsp_tdata
);
   import scsd_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_digit_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[10:7]))
      else $error("digit enable not one-hot");

   a_led_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[13:11]))
      else $error("more than one led lit");

   a_blank_before_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10:7] == 4'd0 |-> rsp_tdata[6:0] == SEG_BLANK)
      else $error("segments driven with no digit enabled");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response transfer changed");

endmodule

bind serial_command_seven_segment_driver_top scsd_check u_scsd_check (.*);
